// File: hw/rtl/rsnh_pkg.sv
// Shared types, constants and command encodings for the ray nearest-hit core.
package rsnh_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int ID_BITS       = 16;
  localparam int DIR_BITS      = 18;
  localparam int LAYER_BITS    = 5;
  localparam int UDIST_BITS    = 31;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam int DIV_STEPS  = COORD_BITS + 1 + FRAC_BITS;
  localparam int SQRT_STEPS = 32;
  localparam int STEP_BITS  = $clog2(SQRT_STEPS);
  localparam int CNT_BITS   = $clog2(DIV_STEPS + 1);

  localparam logic signed [63:0]           UNBOUNDED    = 64'sh4000_0000_0000_0000;
  localparam logic [UDIST_BITS-1:0]        MAX_DIST_RST = '1;
  localparam logic signed [DIR_BITS-1:0]   DIR_ONE      = DIR_BITS'(1 << FRAC_BITS);
  localparam logic                         KIND_CIRCLE  = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_DIR_X    = 3'd2,
    REG_DIR_Y    = 3'd3,
    REG_LAYER    = 3'd4,
    REG_MAX_DIST = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LAYER,
    ST_BAX, ST_BDVA, ST_BSVA, ST_BSTB, ST_BDVB, ST_BSVB, ST_BT,
    ST_CEDGE, ST_CRR, ST_CACC1, ST_CPROJ, ST_CACC2, ST_COUT, ST_CCHK,
    ST_CPNTX, ST_CPNTY, ST_CFAR, ST_CACC3, ST_CINSQ, ST_CSQCHK, ST_CSQRT, ST_CDIST,
    ST_BEST, ST_PTX, ST_COMMIT, ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    M_NONE, M_RR, M_EXD, M_EYD, M_EXX, M_EYY, M_PJX, M_PJY, M_PXX, M_PYY, M_TX, M_TY
  } mul_op_t;

  typedef enum logic [4:0] {
    A_NONE, A_LOAD, A_EDGE, A_SAVE_RR, A_SAVE_ACC, A_PROJ, A_OUTSIDE, A_PNTX, A_PNTY,
    A_INSQ, A_SQRT_STEP, A_CDIST, A_DIV_START, A_DIV_STEP, A_SAVE_QA, A_SLAB_SET,
    A_SLAB_UNB, A_BOX_T, A_PTX, A_COMMIT, A_OUTPUT
  } alu_op_t;

  typedef struct packed {
    mul_op_t              mul_op;
    alu_op_t              alu_op;
    logic                 axis;
    logic                 hi_sel;
    logic [STEP_BITS-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic layer_ok;
    logic circle;
    logic dz;
    logic in_slab;
    logic circ_reject;
    logic far_p;
    logic sq_ok;
    logic better;
  } dp_stat_t;

endpackage

// File: hw/rtl/rsnh_in_if.sv
// Object channel interface: valid, ready and one object description.
interface rsnh_in_if import rsnh_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         query_start;
  logic                         shape_kind;
  logic [ID_BITS-1:0]           object_id;
  logic [LAYER_BITS-1:0]        object_layer;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [UDIST_BITS-1:0]        size_x;
  logic [UDIST_BITS-1:0]        size_y;
  logic [UDIST_BITS-1:0]        radius;

  modport source (output valid, query_start, shape_kind, object_id, object_layer, center_x,
                  center_y, size_x, size_y, radius, input ready);
  modport sink (input valid, query_start, shape_kind, object_id, object_layer, center_x,
                center_y, size_x, size_y, radius, output ready);
endinterface

// File: hw/rtl/rsnh_out_if.sv
// Result channel interface: valid, ready and the nearest-hit report.
interface rsnh_out_if import rsnh_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         new_nearest;
  logic                         any_hit;
  logic [UDIST_BITS-1:0]        nearest_distance;
  logic signed [COORD_BITS-1:0] nearest_x;
  logic signed [COORD_BITS-1:0] nearest_y;
  logic [ID_BITS-1:0]           nearest_id;

  modport source (output valid, new_nearest, any_hit, nearest_distance, nearest_x, nearest_y,
                  nearest_id, input ready);
  modport sink (input valid, new_nearest, any_hit, nearest_distance, nearest_x, nearest_y,
                nearest_id, output ready);
endinterface

// File: hw/rtl/rsnh_dpath.sv
// Datapath: configuration, object registers, shared multiplier, divider, root and best hit.
module rsnh_dpath import rsnh_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                         in_query_start,
  input  logic                         in_shape_kind,
  input  logic [ID_BITS-1:0]           in_object_id,
  input  logic [LAYER_BITS-1:0]        in_object_layer,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [UDIST_BITS-1:0]        in_size_x,
  input  logic [UDIST_BITS-1:0]        in_size_y,
  input  logic [UDIST_BITS-1:0]        in_radius,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  output logic                         out_new_nearest,
  output logic                         out_any_hit,
  output logic [UDIST_BITS-1:0]        out_nearest_distance,
  output logic signed [COORD_BITS-1:0] out_nearest_x,
  output logic signed [COORD_BITS-1:0] out_nearest_y,
  output logic [ID_BITS-1:0]           out_nearest_id
);

  logic signed [COORD_BITS-1:0] ox_r, oy_r, cx_r, cy_r, ptx_r, bx_r, by_r;
  logic signed [DIR_BITS-1:0]   dx_r, dy_r;
  logic [LAYER_BITS-1:0]        layer_r, olayer_r;
  logic [UDIST_BITS-1:0]        maxd_r, r_r, best_dist_r;
  logic [UDIST_BITS-2:0]        hx_r, hy_r;
  logic                         kind_r, hit_seen_r, new_r, hit_r, outside_r, sq_ok_r, neg_r;
  logic [ID_BITS-1:0]           id_r, bid_r;
  logic signed [63:0]           prod_r, acc_r, qa_r, t_r;
  logic [63:0]                  rr_r, v_r, res_r;
  logic signed [COORD_BITS:0]   ex_r, ey_r;
  logic signed [35:0]           proj_r;
  logic signed [39:0]           px_r, py_r;
  logic [DIV_STEPS-1:0]         dvd_r;
  logic [DIR_BITS-1:0]          rem_r, dm_r;
  logic signed [63:0]           slo_r [2];
  logic signed [63:0]           shi_r [2];

  logic signed [36:0]  ma;
  logic signed [31:0]  mb;
  logic signed [68:0]  prod_full;
  logic signed [63:0]  prod_sh, sum64, psh, ptmp, o_a, c_a, h_a, lo_b, hi_b, num, numm;
  logic signed [63:0]  qsigned, entry_t, leave_t, pj, offs, cdist;
  logic signed [DIR_BITS-1:0] d_a;
  logic [63:0]         sumu, sbit, trial;
  logic [COORD_BITS:0] exm, eym;
  logic [39:0]         pxm, pym;
  logic [DIR_BITS:0]   rs;
  logic                ge;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    lo_lim = -hi_lim - 64'sd1;
    if (v > hi_lim) begin
      return hi_lim[COORD_BITS-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  assign exm = ex_r[COORD_BITS] ? (COORD_BITS+1)'(-ex_r) : (COORD_BITS+1)'(ex_r);
  assign eym = ey_r[COORD_BITS] ? (COORD_BITS+1)'(-ey_r) : (COORD_BITS+1)'(ey_r);
  assign pxm = px_r[39] ? 40'(-px_r) : 40'(px_r);
  assign pym = py_r[39] ? 40'(-py_r) : 40'(py_r);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_op)
      M_RR:  begin ma = $signed({6'b0, r_r});        mb = $signed({1'b0, r_r}); end
      M_EXD: begin ma = 37'(ex_r);                   mb = 32'(dx_r); end
      M_EYD: begin ma = 37'(ey_r);                   mb = 32'(dy_r); end
      M_EXX: begin ma = $signed({6'b0, exm[30:0]});  mb = $signed({1'b0, exm[30:0]}); end
      M_EYY: begin ma = $signed({6'b0, eym[30:0]});  mb = $signed({1'b0, eym[30:0]}); end
      M_PJX: begin ma = 37'(proj_r);                 mb = 32'(dx_r); end
      M_PJY: begin ma = 37'(proj_r);                 mb = 32'(dy_r); end
      M_PXX: begin ma = $signed({6'b0, pxm[30:0]});  mb = $signed({1'b0, pxm[30:0]}); end
      M_PYY: begin ma = $signed({6'b0, pym[30:0]});  mb = $signed({1'b0, pym[30:0]}); end
      M_TX:  begin ma = $signed({5'b0, t_r[31:0]});  mb = 32'(dx_r); end
      M_TY:  begin ma = $signed({5'b0, t_r[31:0]});  mb = 32'(dy_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_full = ma * mb;
  assign prod_sh   = prod_r >>> FRAC_BITS;
  assign sum64     = acc_r + prod_r;
  assign sumu      = sum64;
  assign psh       = sum64 >>> FRAC_BITS;
  assign ptmp      = 64'(cmd.mul_op == M_PJY ? cx_r : cy_r) -
                     (64'(cmd.mul_op == M_PJY ? ox_r : oy_r) + prod_sh);

  assign o_a  = cmd.axis ? 64'(oy_r) : 64'(ox_r);
  assign c_a  = cmd.axis ? 64'(cy_r) : 64'(cx_r);
  assign d_a  = cmd.axis ? dy_r : dx_r;
  assign h_a  = $signed({34'b0, (cmd.axis ? hy_r : hx_r)});
  assign lo_b = c_a - h_a;
  assign hi_b = c_a + h_a;
  assign num  = (cmd.hi_sel ? hi_b : lo_b) - o_a;
  assign numm = num[63] ? -num : num;

  assign rs = {rem_r, dvd_r[DIV_STEPS-1]};
  assign ge = rs >= {1'b0, dm_r};
  assign qsigned = neg_r ? -$signed({{(64-DIV_STEPS){1'b0}}, dvd_r})
                         :  $signed({{(64-DIV_STEPS){1'b0}}, dvd_r});

  assign entry_t = (slo_r[0] > slo_r[1]) ? slo_r[0] : slo_r[1];
  assign leave_t = (shi_r[0] < shi_r[1]) ? shi_r[0] : shi_r[1];

  assign sbit  = 64'd1 << (6'd62 - {cmd.step, 1'b0});
  assign trial = res_r + sbit;
  assign pj    = 64'(proj_r);
  assign offs  = $signed(res_r);
  assign cdist = outside_r ? (pj - offs) : (pj + offs);

  always_comb begin
    stat.layer_ok    = (olayer_r == layer_r);
    stat.circle      = (kind_r == KIND_CIRCLE);
    stat.dz          = (d_a == '0);
    stat.in_slab     = (o_a >= lo_b) && (o_a <= hi_b);
    stat.circ_reject = outside_r && proj_r[35];
    stat.far_p       = (pxm > {9'b0, r_r}) || (pym > {9'b0, r_r});
    stat.sq_ok       = sq_ok_r;
    stat.better      = hit_r && (t_r < $signed({33'b0, best_dist_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r        <= '0;
      oy_r        <= '0;
      dx_r        <= DIR_ONE;
      dy_r        <= '0;
      layer_r     <= '0;
      maxd_r      <= MAX_DIST_RST;
      best_dist_r <= MAX_DIST_RST;
      hit_seen_r  <= 1'b0;
      bx_r        <= '0;
      by_r        <= '0;
      bid_r       <= '0;
      new_r       <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORIGIN_X: ox_r    <= cfg_data[COORD_BITS-1:0];
          REG_ORIGIN_Y: oy_r    <= cfg_data[COORD_BITS-1:0];
          REG_DIR_X:    dx_r    <= cfg_data[DIR_BITS-1:0];
          REG_DIR_Y:    dy_r    <= cfg_data[DIR_BITS-1:0];
          REG_LAYER:    layer_r <= cfg_data[LAYER_BITS-1:0];
          REG_MAX_DIST: maxd_r  <= cfg_data[UDIST_BITS-1:0];
          default: ;
        endcase
      end
      case (cmd.alu_op)
        A_LOAD: begin
          new_r <= 1'b0;
          hit_r <= 1'b0;
          if (in_query_start) begin
            best_dist_r <= maxd_r;
            hit_seen_r  <= 1'b0;
            bx_r        <= '0;
            by_r        <= '0;
            bid_r       <= '0;
          end
        end
        A_CDIST: hit_r <= 1'b1;
        A_BOX_T: hit_r <= (leave_t >= entry_t) && (!entry_t[63] || !leave_t[63]);
        A_COMMIT: begin
          best_dist_r <= t_r[UDIST_BITS-1:0];
          bx_r        <= ptx_r;
          by_r        <= sat_coord(64'(oy_r) + prod_sh);
          bid_r       <= id_r;
          hit_seen_r  <= 1'b1;
          new_r       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != M_NONE) begin
      prod_r <= prod_full[63:0];
    end
    case (cmd.alu_op)
      A_LOAD: begin
        kind_r   <= in_shape_kind;
        id_r     <= in_object_id;
        olayer_r <= in_object_layer;
        cx_r     <= in_center_x;
        cy_r     <= in_center_y;
        hx_r     <= in_size_x[UDIST_BITS-1:1];
        hy_r     <= in_size_y[UDIST_BITS-1:1];
        r_r      <= in_radius;
      end
      A_EDGE: begin
        ex_r <= (COORD_BITS+1)'(cx_r) - (COORD_BITS+1)'(ox_r);
        ey_r <= (COORD_BITS+1)'(cy_r) - (COORD_BITS+1)'(oy_r);
      end
      A_SAVE_RR:  rr_r <= prod_r;
      A_SAVE_ACC: acc_r <= prod_r;
      A_PROJ:     proj_r <= psh[35:0];
      A_OUTSIDE: begin
        outside_r <= (exm > {2'b0, r_r}) || (eym > {2'b0, r_r}) || (sumu > rr_r);
      end
      A_PNTX: px_r <= ptmp[39:0];
      A_PNTY: py_r <= ptmp[39:0];
      A_INSQ: begin
        sq_ok_r <= (sumu <= rr_r);
        v_r     <= rr_r - sumu;
        res_r   <= '0;
      end
      A_SQRT_STEP: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + sbit;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      A_CDIST: t_r <= cdist[63] ? 64'sd0 : cdist;
      A_DIV_START: begin
        dvd_r <= {numm[COORD_BITS:0], {FRAC_BITS{1'b0}}};
        dm_r  <= d_a[DIR_BITS-1] ? DIR_BITS'(-d_a) : DIR_BITS'(d_a);
        neg_r <= num[63] ^ d_a[DIR_BITS-1];
        rem_r <= '0;
      end
      A_DIV_STEP: begin
        rem_r <= ge ? DIR_BITS'(rs - {1'b0, dm_r}) : rs[DIR_BITS-1:0];
        dvd_r <= {dvd_r[DIV_STEPS-2:0], ge};
      end
      A_SAVE_QA: qa_r <= qsigned;
      A_SLAB_SET: begin
        slo_r[cmd.axis] <= (qa_r < qsigned) ? qa_r : qsigned;
        shi_r[cmd.axis] <= (qa_r < qsigned) ? qsigned : qa_r;
      end
      A_SLAB_UNB: begin
        slo_r[cmd.axis] <= -UNBOUNDED;
        shi_r[cmd.axis] <= UNBOUNDED;
      end
      A_BOX_T: t_r <= entry_t[63] ? leave_t : entry_t;
      A_PTX:   ptx_r <= sat_coord(64'(ox_r) + prod_sh);
      A_OUTPUT: begin
        out_new_nearest      <= new_r;
        out_any_hit          <= hit_seen_r;
        out_nearest_distance <= best_dist_r;
        out_nearest_x        <= bx_r;
        out_nearest_y        <= by_r;
        out_nearest_id       <= bid_r;
      end
      default: ;
    endcase
  end

  a_commit_better: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alu_op == A_COMMIT) |-> stat.better)
    else $error("commit without a closer hit");

  a_sqrt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alu_op == A_SQRT_STEP) |-> sq_ok_r)
    else $error("square root started on a missed circle");

endmodule

// File: hw/rtl/rsnh_ctrl.sv
// Controller: sequences the datapath for box and circle tests and runs the handshakes.
module rsnh_ctrl import rsnh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t         state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                ax_r, ax_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ax_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ax_nxt        = ax_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.mul_op    = M_NONE;
    cmd.alu_op    = A_NONE;
    cmd.axis      = ax_r;
    cmd.hi_sel    = 1'b0;
    cmd.step      = cnt_r[STEP_BITS-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.alu_op = A_LOAD;
          state_nxt  = ST_LAYER;
        end
      end
      ST_LAYER: begin
        ax_nxt = 1'b0;
        if (!stat.layer_ok) begin
          state_nxt = ST_DONE;
        end else if (stat.circle) begin
          state_nxt = ST_CEDGE;
        end else begin
          state_nxt = ST_BAX;
        end
      end
      ST_BAX: begin
        if (stat.dz) begin
          if (!stat.in_slab) begin
            state_nxt = ST_BEST;
          end else begin
            cmd.alu_op = A_SLAB_UNB;
            if (ax_r) begin
              state_nxt = ST_BT;
            end else begin
              ax_nxt = 1'b1;
            end
          end
        end else begin
          cmd.alu_op = A_DIV_START;
          cnt_nxt    = '0;
          state_nxt  = ST_BDVA;
        end
      end
      ST_BDVA, ST_BDVB: begin
        cmd.alu_op = A_DIV_STEP;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_STEPS - 1)) begin
          state_nxt = (state_r == ST_BDVA) ? ST_BSVA : ST_BSVB;
        end
      end
      ST_BSVA: begin
        cmd.alu_op = A_SAVE_QA;
        state_nxt  = ST_BSTB;
      end
      ST_BSTB: begin
        cmd.alu_op = A_DIV_START;
        cmd.hi_sel = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_BDVB;
      end
      ST_BSVB: begin
        cmd.alu_op = A_SLAB_SET;
        if (ax_r) begin
          state_nxt = ST_BT;
        end else begin
          ax_nxt    = 1'b1;
          state_nxt = ST_BAX;
        end
      end
      ST_BT: begin
        cmd.alu_op = A_BOX_T;
        state_nxt  = ST_BEST;
      end
      ST_CEDGE: begin
        cmd.mul_op = M_RR;
        cmd.alu_op = A_EDGE;
        state_nxt  = ST_CRR;
      end
      ST_CRR: begin
        cmd.mul_op = M_EXD;
        cmd.alu_op = A_SAVE_RR;
        state_nxt  = ST_CACC1;
      end
      ST_CACC1: begin
        cmd.mul_op = M_EYD;
        cmd.alu_op = A_SAVE_ACC;
        state_nxt  = ST_CPROJ;
      end
      ST_CPROJ: begin
        cmd.mul_op = M_EXX;
        cmd.alu_op = A_PROJ;
        state_nxt  = ST_CACC2;
      end
      ST_CACC2: begin
        cmd.mul_op = M_EYY;
        cmd.alu_op = A_SAVE_ACC;
        state_nxt  = ST_COUT;
      end
      ST_COUT: begin
        cmd.alu_op = A_OUTSIDE;
        state_nxt  = ST_CCHK;
      end
      ST_CCHK: begin
        if (stat.circ_reject) begin
          state_nxt = ST_BEST;
        end else begin
          cmd.mul_op = M_PJX;
          state_nxt  = ST_CPNTX;
        end
      end
      ST_CPNTX: begin
        cmd.mul_op = M_PJY;
        cmd.alu_op = A_PNTX;
        state_nxt  = ST_CPNTY;
      end
      ST_CPNTY: begin
        cmd.alu_op = A_PNTY;
        state_nxt  = ST_CFAR;
      end
      ST_CFAR: begin
        if (stat.far_p) begin
          state_nxt = ST_BEST;
        end else begin
          cmd.mul_op = M_PXX;
          state_nxt  = ST_CACC3;
        end
      end
      ST_CACC3: begin
        cmd.mul_op = M_PYY;
        cmd.alu_op = A_SAVE_ACC;
        state_nxt  = ST_CINSQ;
      end
      ST_CINSQ: begin
        cmd.alu_op = A_INSQ;
        state_nxt  = ST_CSQCHK;
      end
      ST_CSQCHK: begin
        cnt_nxt   = '0;
        state_nxt = stat.sq_ok ? ST_CSQRT : ST_BEST;
      end
      ST_CSQRT: begin
        cmd.alu_op = A_SQRT_STEP;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(SQRT_STEPS - 1)) begin
          state_nxt = ST_CDIST;
        end
      end
      ST_CDIST: begin
        cmd.alu_op = A_CDIST;
        state_nxt  = ST_BEST;
      end
      ST_BEST: begin
        if (stat.better) begin
          cmd.mul_op = M_TX;
          state_nxt  = ST_PTX;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PTX: begin
        cmd.mul_op = M_TY;
        cmd.alu_op = A_PTX;
        state_nxt  = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.alu_op = A_COMMIT;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.alu_op    = A_OUTPUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("controller idle right after accepting an object");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BDVA || state_r == ST_BDVB) |-> (cnt_r < CNT_BITS'(DIV_STEPS)))
    else $error("divider step count overrun");

  a_done_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished result not published");

endmodule

// File: hw/rtl/ray_shape_nearest_hit_core.sv
// Top level of the 2D ray nearest-hit core: controller, datapath and channel ports.
// One object is worked on at a time. For a circle the work is set mostly by the 32-step
// square root; for a box it is set by four 49-step bit-serial divisions (two slab bounds
// per axis) in the one divider; an axis with a zero direction component skips its two
// divisions. The result sits in an output register, so the next object is accepted while
// the last result waits to be taken.
module ray_shape_nearest_hit_core import rsnh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  rsnh_in_if.sink                  in_ch,
  rsnh_out_if.source               out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rsnh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsnh_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_query_start       (in_ch.query_start),
    .in_shape_kind        (in_ch.shape_kind),
    .in_object_id         (in_ch.object_id),
    .in_object_layer      (in_ch.object_layer),
    .in_center_x          (in_ch.center_x),
    .in_center_y          (in_ch.center_y),
    .in_size_x            (in_ch.size_x),
    .in_size_y            (in_ch.size_y),
    .in_radius            (in_ch.radius),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_new_nearest      (out_ch.new_nearest),
    .out_any_hit          (out_ch.any_hit),
    .out_nearest_distance (out_ch.nearest_distance),
    .out_nearest_x        (out_ch.nearest_x),
    .out_nearest_y        (out_ch.nearest_y),
    .out_nearest_id       (out_ch.nearest_id)
  );

endmodule
